FILE: rtl/bcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants for the button click / long press detector.
// ----------------------------------------------------------------------------
package bcl_pkg;

    // timestamp width, time differences wrap at this width
    localparam int TIME_W = 32;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 4;
    localparam int TALLY_W   = 8;
    localparam int EVT_W     = 4;
    localparam int OUT_EV_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_CLICK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_CT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LONG    = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_LONG_PRESS  = 16'd0;
    localparam logic [CFG_W-1:0] RST_MULTI_CLICK = 16'd0;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS = 16'd50;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE_CT = 4'd3;
    localparam logic [CFG_W-1:0] RST_MIN_LONG    = 16'd500;

    // internal event history codes
    localparam logic [EVT_W-1:0] EV_NONE         = 4'd0;
    localparam logic [EVT_W-1:0] EV_PRESS        = 4'd1;
    localparam logic [EVT_W-1:0] EV_PRESS_IDLE   = 4'd2;
    localparam logic [EVT_W-1:0] EV_RELEASE      = 4'd3;
    localparam logic [EVT_W-1:0] EV_HOLD         = 4'd4;
    localparam logic [EVT_W-1:0] EV_HOLD_RELEASE = 4'd5;
    localparam logic [EVT_W-1:0] EV_CLICK_BASE   = 4'd6;

    // output codes
    localparam logic [OUT_EV_W-1:0] EDGE_NONE   = 3'd0;
    localparam logic [OUT_EV_W-1:0] CLICK_NONE  = 3'd0;
    localparam logic [OUT_EV_W-1:0] CLICK_ONE   = 3'd1;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [1:0]         CLICK_IDX_MAX = 2'd3;

    // derived configuration seen by the step logic
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CNT_W-1:0] debounce_count;
        logic [CFG_W-1:0] eff_long;
        logic [CFG_W-1:0] window;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [OUT_EV_W-1:0] edge_event;
        logic [OUT_EV_W-1:0] click_event;
        logic                stable_pressed;
    } t_result;

endpackage

FILE: rtl/bcl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_cfg_regs
// Configuration registers with the long press floor and click window derived.
// ----------------------------------------------------------------------------
module bcl_cfg_regs import bcl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [CFG_W-1:0] r_long_press;
    logic [CFG_W-1:0] r_multi_click;
    logic [CFG_W-1:0] r_debounce_ms;
    logic [CNT_W-1:0] r_debounce_ct;
    logic [CFG_W-1:0] r_min_long;
    logic [CFG_W-1:0] eff_long;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press  <= RST_LONG_PRESS;
            r_multi_click <= RST_MULTI_CLICK;
            r_debounce_ms <= RST_DEBOUNCE_MS;
            r_debounce_ct <= RST_DEBOUNCE_CT;
            r_min_long    <= RST_MIN_LONG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LONG_PRESS:  r_long_press  <= i_cfg_data;
                REG_MULTI_CLICK: r_multi_click <= i_cfg_data;
                REG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data;
                REG_DEBOUNCE_CT: r_debounce_ct <= i_cfg_data[CNT_W-1:0];
                REG_MIN_LONG:    r_min_long    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // long press time raised to its floor, zero window falls back to it
    assign eff_long = (r_long_press < r_min_long) ? r_min_long : r_long_press;

    assign o_cfg.debounce_ms    = r_debounce_ms;
    assign o_cfg.debounce_count = r_debounce_ct;
    assign o_cfg.eff_long       = eff_long;
    assign o_cfg.window         = (r_multi_click != '0) ? r_multi_click : eff_long;

endmodule

FILE: rtl/bcl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_step
// Debounce, edge event and multi-click state with the per-item update logic.
// ----------------------------------------------------------------------------
module bcl_step import bcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_pin_pressed,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic               r_stable;
    logic [TIME_W-1:0]  r_last_tick;
    logic [CNT_W-1:0]   r_press_samples;
    logic [CNT_W-1:0]   r_release_samples;
    logic [TIME_W-1:0]  r_press_start;
    logic [TIME_W-1:0]  r_release_stamp;
    logic [TIME_W-1:0]  r_hold_stamp;
    logic               r_hold_valid;
    logic               r_holding_long;
    logic               r_multi_waiting;
    logic [TALLY_W-1:0] r_click_tally;
    logic [TIME_W-1:0]  r_window_start;
    logic [EVT_W-1:0]   r_current_event;
    logic [EVT_W-1:0]   r_previous_event;

    logic               n_stable;
    logic [CNT_W-1:0]   n_press_samples;
    logic [CNT_W-1:0]   n_release_samples;
    logic [TIME_W-1:0]  n_press_start;
    logic [TIME_W-1:0]  n_release_stamp;
    logic [TIME_W-1:0]  n_hold_stamp;
    logic               n_hold_valid;
    logic               n_holding_long;
    logic               n_multi_waiting;
    logic [TALLY_W-1:0] n_click_tally;
    logic [TIME_W-1:0]  n_window_start;
    logic [EVT_W-1:0]   n_current_event;
    logic [EVT_W-1:0]   n_previous_event;

    logic [TIME_W-1:0]  diff_tick;
    logic [TIME_W-1:0]  diff_hold;
    logic [TIME_W-1:0]  diff_release;
    logic [TIME_W-1:0]  diff_press;
    logic [TIME_W-1:0]  diff_window;
    logic [TIME_W-1:0]  deb_time;
    logic [TIME_W-1:0]  eff_time;
    logic [TIME_W-1:0]  half_eff_time;
    logic [TIME_W-1:0]  window_time;

    // low bits of the tally minus one
    function automatic logic [1:0] click_idx_of(input logic [TALLY_W-1:0] tally);
        logic [TALLY_W-1:0] dec;
        dec = tally - 1'b1;
        return dec[1:0];
    endfunction

    // wrapping time differences against the stored stamps
    assign diff_tick     = i_now_ms - r_last_tick;
    assign diff_hold     = i_now_ms - r_hold_stamp;
    assign diff_release  = i_now_ms - r_release_stamp;
    assign diff_press    = i_now_ms - r_press_start;
    assign diff_window   = i_now_ms - r_window_start;
    assign deb_time      = TIME_W'(i_cfg.debounce_ms);
    assign eff_time      = TIME_W'(i_cfg.eff_long);
    assign half_eff_time = TIME_W'(i_cfg.eff_long[CFG_W-1:1]);
    assign window_time   = TIME_W'(i_cfg.window);

    // per-item update
    always_comb begin
        logic [1:0] click_idx;

        n_stable          = r_stable;
        n_press_samples   = r_press_samples;
        n_release_samples = r_release_samples;
        n_press_start     = r_press_start;
        n_release_stamp   = r_release_stamp;
        n_hold_stamp      = r_hold_stamp;
        n_hold_valid      = r_hold_valid;
        n_holding_long    = r_holding_long;
        n_multi_waiting   = r_multi_waiting;
        n_click_tally     = r_click_tally;
        n_window_start    = r_window_start;
        n_current_event   = r_current_event;
        n_previous_event  = r_previous_event;
        o_result.edge_event  = EDGE_NONE;
        o_result.click_event = CLICK_NONE;
        click_idx = '0;

        // debounce, skipped when the timestamp has not moved
        if (diff_tick != '0) begin
            if (i_pin_pressed) begin
                if (!r_stable) begin
                    if (r_press_samples != CNT_MAX) begin
                        n_press_samples = r_press_samples + 1'b1;
                    end
                    if (diff_tick >= deb_time || n_press_samples >= i_cfg.debounce_count) begin
                        n_press_samples = '0;
                        n_stable        = 1'b1;
                        n_press_start   = i_now_ms;
                    end
                end
                n_release_samples = '0;
            end else begin
                if (r_stable) begin
                    if (r_release_samples != CNT_MAX) begin
                        n_release_samples = r_release_samples + 1'b1;
                    end
                    if (diff_tick >= deb_time
                        || n_release_samples >= i_cfg.debounce_count) begin
                        n_release_samples = '0;
                        n_stable          = 1'b0;
                    end
                end
                n_press_samples = '0;
            end
        end

        // event stage, suppressed while cooling after a long hold
        if (!(r_hold_valid && diff_hold < half_eff_time && n_stable)) begin
            // edge events
            if (r_stable != n_stable) begin
                if (n_stable) begin
                    n_current_event = (diff_release >= eff_time) ? EV_PRESS_IDLE : EV_PRESS;
                end else begin
                    n_release_stamp = i_now_ms;
                    if (r_holding_long) begin
                        n_holding_long  = 1'b0;
                        n_current_event = EV_HOLD_RELEASE;
                        n_multi_waiting = 1'b0;
                    end else begin
                        n_current_event = EV_RELEASE;
                    end
                end
                o_result.edge_event = n_current_event[OUT_EV_W-1:0];
            end else if (n_stable && !r_holding_long && diff_press >= eff_time) begin
                n_holding_long      = 1'b1;
                n_current_event     = EV_HOLD;
                n_hold_stamp        = i_now_ms;
                n_hold_valid        = 1'b1;
                o_result.edge_event = n_current_event[OUT_EV_W-1:0];
            end

            // multi-click counting
            if (!n_multi_waiting) begin
                if (r_previous_event != n_current_event && n_stable) begin
                    n_click_tally   = '0;
                    n_multi_waiting = 1'b1;
                    n_window_start  = i_now_ms;
                end
            end else if (diff_window <= window_time) begin
                if (r_previous_event != n_current_event) begin
                    n_window_start = i_now_ms;
                    if (n_current_event == EV_RELEASE && r_click_tally != TALLY_MAX) begin
                        n_click_tally = r_click_tally + 1'b1;
                    end
                end
            end else if (!n_stable) begin
                if (r_click_tally != '0) begin
                    click_idx = (r_click_tally - 1'b1 > TALLY_W'(CLICK_IDX_MAX))
                        ? CLICK_IDX_MAX : click_idx_of(r_click_tally);
                    n_current_event      = EV_CLICK_BASE + EVT_W'(click_idx);
                    o_result.click_event = CLICK_ONE + OUT_EV_W'(click_idx);
                end
                n_click_tally   = '0;
                n_multi_waiting = 1'b0;
            end

            n_previous_event = n_current_event;
        end

        o_result.stable_pressed = n_stable;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable          <= 1'b0;
            r_last_tick       <= '0;
            r_press_samples   <= '0;
            r_release_samples <= '0;
            r_press_start     <= '0;
            r_release_stamp   <= '0;
            r_hold_stamp      <= '0;
            r_hold_valid      <= 1'b0;
            r_holding_long    <= 1'b0;
            r_multi_waiting   <= 1'b0;
            r_click_tally     <= '0;
            r_window_start    <= '0;
            r_current_event   <= EV_NONE;
            r_previous_event  <= EV_NONE;
        end else if (i_en) begin
            r_stable          <= n_stable;
            r_last_tick       <= i_now_ms;
            r_press_samples   <= n_press_samples;
            r_release_samples <= n_release_samples;
            r_press_start     <= n_press_start;
            r_release_stamp   <= n_release_stamp;
            r_hold_stamp      <= n_hold_stamp;
            r_hold_valid      <= n_hold_valid;
            r_holding_long    <= n_holding_long;
            r_multi_waiting   <= n_multi_waiting;
            r_click_tally     <= n_click_tally;
            r_window_start    <= n_window_start;
            r_current_event   <= n_current_event;
            r_previous_event  <= n_previous_event;
        end
    end

endmodule

FILE: rtl/button_click_long_press_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_long_press_detector
// Debounces a button sample stream and reports press / hold / release edges
// and single, double, triple or repeat clicks, one result item per tick.
// ----------------------------------------------------------------------------
// pipeline: input register, then the state update and result register in one
//   pass; an item waits in the input register while the output stalls
// throughput: one item per cycle, limited only by the output stall
// reset: synchronous active low; clears config to defaults, all debounce,
//   hold and click state, and both pipeline valid flags
module button_click_long_press_detector import bcl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_pin_pressed,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_EV_W-1:0]  o_edge_event,
    output logic [OUT_EV_W-1:0]  o_click_event,
    output logic                 o_stable_pressed
);

    t_cfg              cfg;
    t_result           step_result;
    logic              step_en;
    logic              in_take;
    logic              r_in_valid;
    logic [TIME_W-1:0] r_now_ms;
    logic              r_pin;
    logic              r_out_valid;
    t_result           r_result;

    bcl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // item moves into the result register when that register is free or draining
    assign step_en = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step_en;
    assign in_take = i_valid && !o_stall;

    bcl_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (step_en),
        .i_now_ms      (r_now_ms),
        .i_pin_pressed (r_pin),
        .i_cfg         (cfg),
        .o_result      (step_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now_ms <= i_now_ms;
            r_pin    <= i_pin_pressed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_result <= step_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_edge_event     = r_result.edge_event;
    assign o_click_event    = r_result.click_event;
    assign o_stable_pressed = r_result.stable_pressed;

endmodule
